FILE: rtl/tirs_pkg.sv
// Shared types and constants for the time-indexed ring search block.
package tirs_pkg;

  // Coordinate width (signed Q16.16) and width of index/count fields
  localparam int COORD_W = 32;
  localparam int FIELD_W = 11;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_WINDOW  = 2'd1,
    REQ_NEAREST = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_kind_t;

  // Answer kinds
  localparam logic ANS_WINDOW  = 1'b0;
  localparam logic ANS_NEAREST = 1'b1;

  // Request word
  typedef struct packed {
    req_kind_t                  req_type;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  window_low;
    logic signed [COORD_W-1:0]  window_high;
    logic signed [COORD_W-1:0]  probe_x;
  } req_word_t;

  // Answer word
  typedef struct packed {
    logic                       answer_kind;
    logic [FIELD_W-1:0]         range_first;
    logic [FIELD_W-1:0]         range_end;
    logic signed [COORD_W-1:0]  near_x;
    logic signed [COORD_W-1:0]  near_y;
    logic                       store_empty;
    logic [FIELD_W-1:0]         fill_level;
  } ans_word_t;

  // Capacity register word
  typedef logic [FIELD_W-1:0] cfg_word_t;

endpackage

FILE: rtl/tirs_if.sv
// Valid/ready channel interfaces for requests, answers and the capacity register.
interface tirs_req_if;
  import tirs_pkg::*;
  logic      valid;
  logic      ready;
  req_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface tirs_ans_if;
  import tirs_pkg::*;
  logic      valid;
  logic      ready;
  ans_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface tirs_cfg_if;
  import tirs_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/tirs_point_ram.sv
// Point store: x and y arrays, one write port and one registered read port.
module tirs_point_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic signed [tirs_pkg::COORD_W-1:0] wr_x,
  input  logic signed [tirs_pkg::COORD_W-1:0] wr_y,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic signed [tirs_pkg::COORD_W-1:0] rd_x,
  output logic signed [tirs_pkg::COORD_W-1:0] rd_y
);
  import tirs_pkg::*;

  logic signed [COORD_W-1:0] x_mem [DEPTH];
  logic signed [COORD_W-1:0] y_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

endmodule

FILE: rtl/time_indexed_ring_search.sv
// Top level: ring store of (x,y) points with window and nearest-point searches.
//
// Points are written into a ring of capacity_in_use entries (clamped to 2..MAX_POINTS);
// once full, each write overwrites the oldest point, and index 0 of every answer is the
// oldest point held. Writes and clears are taken one per cycle. A query holds off the
// request channel until its answer is in the output register; every probe of the store
// puts out an address, then compares the data from the single registered read port, and
// each search is a binary search over the points held. A window query does its range
// checks at the ends of the store and then up to two searches, a nearest query its end
// checks and then at most one search; these end checks can finish a query on their own.
// A query may finish while an earlier answer still waits in the output register; it then
// waits until that word is taken. Writing the capacity register empties the store; the
// register word is taken only while the block is idle and no request word is offered.
module time_indexed_ring_search #(
  parameter int MAX_POINTS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  tirs_req_if.sink   req,
  tirs_ans_if.source ans,
  tirs_cfg_if.sink   cfg
);
  import tirs_pkg::*;

  localparam int AW        = $clog2(MAX_POINTS);
  localparam int CW        = $clog2(MAX_POINTS + 1);
  localparam int SW        = AW + 1;
  localparam int WW        = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int CAP_RESET = (MAX_POINTS < 1024) ? MAX_POINTS : 1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_FIRST,
    ST_WIN_LO,
    ST_WIN_HI,
    ST_WIN_END,
    ST_NEAR_LAST,
    ST_PROBE,
    ST_STEP,
    ST_NEAR_A,
    ST_NEAR_B,
    ST_NEAR_PICK,
    ST_HOLD
  } state_t;

  state_t                    state;
  logic [CW-1:0]             cap;
  logic [AW-1:0]             wp;
  logic [CW-1:0]             fill;
  logic                      near_mode;
  logic                      search_hi;
  logic signed [COORD_W-1:0] wl;
  logic signed [COORD_W-1:0] wh;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] x_first;
  logic signed [COORD_W-1:0] x_last;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;
  logic [COORD_W:0]          da;
  logic [CW-1:0]             res_first;
  logic [CW-1:0]             res_end;
  logic signed [COORD_W-1:0] res_x;
  logic signed [COORD_W-1:0] res_y;
  logic                      out_full;
  ans_word_t                 result;

  logic                      req_fire;
  logic                      cfg_fire;
  logic                      wr_en;
  logic [CW-1:0]             mid;
  logic [CW-1:0]             idx_sel;
  logic [AW-1:0]             rd_idx;
  logic [AW-1:0]             rd_addr;
  logic [SW-1:0]             ring_sum;
  logic [SW-1:0]             ring_wrap;
  logic [SW-1:0]             wp_inc;
  logic [AW-1:0]             wp_next;
  logic [WW-1:0]             cfg_ext;
  logic [CW-1:0]             cap_next;
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic signed [COORD_W-1:0] cmp_a;
  logic signed [COORD_W-1:0] cmp_b;
  logic                      cmp_lt;
  logic                      cmp_eq;
  logic [COORD_W:0]          diff_now;

  // |a - b| without overflow
  function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? (COORD_W + 1)'(-d) : (COORD_W + 1)'(d);
  endfunction

  // handshakes; the register word only lands while idle with no request offered
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = (state == ST_IDLE) & ~req.valid;
  assign req_fire  = req.valid & req.ready;
  assign cfg_fire  = cfg.valid & cfg.ready;
  assign wr_en     = req_fire && (req.word.req_type == REQ_WRITE);

  assign ans.valid = out_full;
  assign ans.word  = result;

  // capacity clamp on register write
  assign cfg_ext = WW'(cfg.word);
  always_comb begin
    priority if (cfg_ext < WW'(2)) begin
      cap_next = CW'(2);
    end else if (cfg_ext > WW'(MAX_POINTS)) begin
      cap_next = CW'(MAX_POINTS);
    end else begin
      cap_next = CW'(cfg_ext);
    end
  end

  // write pointer advance
  assign wp_inc  = SW'(wp) + SW'(1);
  assign wp_next = (wp_inc >= SW'(cap)) ? '0 : wp_inc[AW-1:0];

  // search midpoint
  assign mid = lo + ((hi - lo) >> 1);

  // logical index wanted by the next read
  always_comb begin
    unique case (state)
      ST_IDLE:      idx_sel = fill - CW'(1);
      ST_NEAR_LAST: idx_sel = fill - CW'(1);
      ST_PROBE:     idx_sel = (lo < hi) ? mid : lo - CW'(1);
      ST_NEAR_A:    idx_sel = lo;
      ST_NEAR_B:    idx_sel = lo - CW'(1);
      default:      idx_sel = '0;
    endcase
  end
  assign rd_idx = idx_sel[AW-1:0];

  // oldest-first index to ring slot
  assign ring_sum  = SW'(wp) + SW'(rd_idx);
  assign ring_wrap = ring_sum - SW'(cap);
  always_comb begin
    priority if (fill < cap) begin
      rd_addr = rd_idx;
    end else if (ring_sum >= SW'(cap)) begin
      rd_addr = ring_wrap[AW-1:0];
    end else begin
      rd_addr = ring_sum[AW-1:0];
    end
  end

  tirs_point_ram #(
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_x    (req.word.point_x),
    .wr_y    (req.word.point_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // shared compare unit: operand select per step
  always_comb begin
    cmp_a = rd_x;
    cmp_b = px;
    unique case (state)
      ST_LAST:      cmp_b = wl;
      ST_FIRST:     cmp_b = near_mode ? px : wh;
      ST_WIN_LO: begin
        cmp_a = x_first;
        cmp_b = wl;
      end
      ST_WIN_HI: begin
        cmp_a = x_last;
        cmp_b = wh;
      end
      ST_NEAR_LAST: begin
        cmp_a = x_last;
        cmp_b = px;
      end
      ST_STEP:      cmp_b = near_mode ? px : (search_hi ? wh : wl);
      default: begin
        cmp_a = rd_x;
        cmp_b = px;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  assign diff_now = abs_diff(rd_x, px);

  // sequencer, ring pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cap      <= CW'(CAP_RESET);
      wp       <= '0;
      fill     <= '0;
      out_full <= 1'b0;
    end else begin
      // word taken; the hold step reloads it itself
      if (out_full && ans.ready && state != ST_HOLD) begin
        out_full <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            unique case (req.word.req_type)
              REQ_WRITE: begin
                wp <= wp_next;
                if (fill < cap) begin
                  fill <= fill + CW'(1);
                end
              end
              REQ_CLEAR: begin
                wp   <= '0;
                fill <= '0;
              end
              REQ_WINDOW, REQ_NEAREST: begin
                near_mode <= (req.word.req_type == REQ_NEAREST);
                wl        <= req.word.window_low;
                wh        <= req.word.window_high;
                px        <= req.word.probe_x;
                res_first <= '0;
                res_end   <= '0;
                res_x     <= '0;
                res_y     <= '0;
                state     <= (fill == '0) ? ST_HOLD : ST_LAST;
              end
              default: ;
            endcase
          end
        end

        // rd_x holds the newest point
        ST_LAST: begin
          if (!near_mode && cmp_lt) begin
            res_first <= fill - CW'(1);
            res_end   <= fill - CW'(1);
            state     <= ST_HOLD;
          end else if (near_mode && fill == CW'(1)) begin
            res_x <= rd_x;
            res_y <= rd_y;
            state <= ST_HOLD;
          end else begin
            x_last <= rd_x;
            state  <= ST_FIRST;
          end
        end

        // rd_x holds the oldest point
        ST_FIRST: begin
          if (near_mode) begin
            if (!cmp_lt) begin
              res_x <= rd_x;
              res_y <= rd_y;
              state <= ST_HOLD;
            end else begin
              state <= ST_NEAR_LAST;
            end
          end else if (!cmp_lt && !cmp_eq) begin
            state <= ST_HOLD;
          end else begin
            x_first <= rd_x;
            res_end <= fill;
            state   <= ST_WIN_LO;
          end
        end

        ST_WIN_LO: begin
          if (cmp_lt) begin
            lo        <= '0;
            hi        <= fill;
            search_hi <= 1'b0;
            state     <= ST_PROBE;
          end else begin
            state <= ST_WIN_HI;
          end
        end

        ST_WIN_HI: begin
          if (!cmp_lt && !cmp_eq) begin
            lo        <= '0;
            hi        <= fill;
            search_hi <= 1'b1;
            state     <= ST_PROBE;
          end else begin
            state <= ST_WIN_END;
          end
        end

        ST_WIN_END: begin
          if (res_first > res_end) begin
            res_first <= '0;
            res_end   <= '0;
          end
          state <= ST_HOLD;
        end

        // newest point at or left of the probe wins outright
        ST_NEAR_LAST: begin
          if (cmp_lt || cmp_eq) begin
            state <= ST_NEAR_PICK;
          end else begin
            lo        <= '0;
            hi        <= fill;
            search_hi <= 1'b0;
            state     <= ST_PROBE;
          end
        end

        // issue midpoint read, or finish the search
        ST_PROBE: begin
          if (lo < hi) begin
            state <= ST_STEP;
          end else if (near_mode) begin
            state <= ST_NEAR_A;
          end else if (search_hi) begin
            res_end <= lo;
            state   <= ST_WIN_END;
          end else begin
            res_first <= lo;
            state     <= ST_WIN_HI;
          end
        end

        // halve the interval; upper search steps right on equal too
        ST_STEP: begin
          if (cmp_lt || (search_hi && cmp_eq)) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= ST_PROBE;
        end

        // rd_x holds the point before the bound
        ST_NEAR_A: begin
          da    <= diff_now;
          state <= ST_NEAR_B;
        end

        // rd_x holds the bound point; ties go to the earlier one
        ST_NEAR_B: begin
          if (da > diff_now) begin
            res_x <= rd_x;
            res_y <= rd_y;
            state <= ST_HOLD;
          end else begin
            state <= ST_NEAR_PICK;
          end
        end

        ST_NEAR_PICK: begin
          res_x <= rd_x;
          res_y <= rd_y;
          state <= ST_HOLD;
        end

        // wait for the output register to free up
        ST_HOLD: begin
          if (!out_full || ans.ready) begin
            result.answer_kind <= near_mode ? ANS_NEAREST : ANS_WINDOW;
            result.range_first <= FIELD_W'(res_first);
            result.range_end   <= FIELD_W'(res_end);
            result.near_x      <= res_x;
            result.near_y      <= res_y;
            result.store_empty <= (fill == '0);
            result.fill_level  <= FIELD_W'(fill);
            out_full           <= 1'b1;
            state              <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase

      // register write empties the store
      if (cfg_fire) begin
        cap  <= cap_next;
        wp   <= '0;
        fill <= '0;
      end
    end
  end

  // ring invariants
  a_fill_in_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= cap)
    else $error("fill count above capacity");

  a_wp_in_cap: assert property (@(posedge clk) disable iff (rst)
    SW'(wp) < SW'(cap))
    else $error("write pointer outside ring");

  // search interval sane while stepping
  a_step_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (lo < hi && hi <= fill))
    else $error("search interval out of range");

  // answers only appear from the hold step
  a_ans_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state == ST_HOLD))
    else $error("answer loaded outside hold step");

  // a write into a ring that is not full grows it by one
  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !cfg_fire && fill < cap) |=> (fill == $past(fill) + CW'(1)))
    else $error("fill count did not advance on write");

endmodule

FILE: sim/tb_top.sv
// Testbench for the ring store search block: answer words checked against a predictor.
module tb_top;
  import tirs_pkg::*;

  localparam int RING_DEPTH    = 1024;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 5000;
  localparam int ONE           = 65536;  // 1.0 in Q16.16
  localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] X_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  tirs_req_if req ();
  tirs_ans_if ans ();
  tirs_cfg_if cfg ();

  time_indexed_ring_search dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .ans (ans),
    .cfg (cfg)
  );

  // Predicted contents of the ring
  logic signed [31:0] ring_x [RING_DEPTH];
  logic signed [31:0] ring_y [RING_DEPTH];
  int unsigned        head_pos;
  int unsigned        held;
  logic [10:0]        cap_reg;

  ans_word_t pending_answers [$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;

  // Rising series used to build well-formed streams
  longint run_x, run_base, last_step;

  function automatic int unsigned live_capacity();
    if (cap_reg < 2) return 2;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return 32'(cap_reg);
  endfunction

  // Physical slot of a logical index, oldest first
  function automatic int unsigned slot_of(int unsigned idx);
    int unsigned c, p;
    c = live_capacity();
    if (held < c) begin
      p = idx;
    end else begin
      p = head_pos + idx;
      if (p >= c) p -= c;
    end
    return p % RING_DEPTH;
  endfunction

  function automatic logic signed [31:0] x_at(int unsigned idx);
    return ring_x[slot_of(idx)];
  endfunction

  // First index whose x is not below v (past set: whose x is above v)
  function automatic int unsigned search_x(int unsigned n, logic signed [31:0] v, bit past);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (past ? (x_at(mid) <= v) : (x_at(mid) < v)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic longint x_dist(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Applies one accepted request word; returns 1 with the answer a query gives
  function automatic bit apply_request(input req_word_t w, output ans_word_t a);
    int unsigned n, c, lo, pick;
    a = '0;
    n = held;
    case (w.req_type)
      REQ_WRITE: begin
        c = live_capacity();
        ring_x[head_pos % RING_DEPTH] = w.point_x;
        ring_y[head_pos % RING_DEPTH] = w.point_y;
        head_pos = (head_pos + 1 >= c) ? 0 : head_pos + 1;
        if (held < c) held++;
        return 1'b0;
      end
      REQ_CLEAR: begin
        head_pos = 0;
        held = 0;
        return 1'b0;
      end
      REQ_WINDOW: begin
        a.answer_kind = ANS_WINDOW;
        if (n != 0 && x_at(n - 1) < w.window_low) begin
          // every point left of the window
          a.range_first = 11'(n - 1);
          a.range_end = 11'(n - 1);
        end else if (n != 0 && x_at(0) <= w.window_high) begin
          a.range_first = '0;
          a.range_end = 11'(n);
          if (x_at(0) < w.window_low)
            a.range_first = 11'(search_x(n, w.window_low, 1'b0));
          if (x_at(n - 1) > w.window_high)
            a.range_end = 11'(search_x(n, w.window_high, 1'b1));
          if (a.range_first > a.range_end) begin
            a.range_first = '0;
            a.range_end = '0;
          end
        end
      end
      default: begin
        a.answer_kind = ANS_NEAREST;
        if (n != 0) begin
          if (n == 1 || x_at(0) >= w.probe_x) begin
            pick = 0;
          end else if (x_at(n - 1) <= w.probe_x) begin
            pick = n - 1;
          end else begin
            lo = search_x(n, w.probe_x, 1'b0);
            if (lo == 0) pick = 0;
            else if (lo >= n) pick = n - 1;
            else if (x_dist(x_at(lo - 1), w.probe_x) > x_dist(x_at(lo), w.probe_x)) pick = lo;
            else pick = lo - 1;  // ties go to the earlier point
          end
          a.near_x = ring_x[slot_of(pick)];
          a.near_y = ring_y[slot_of(pick)];
        end
      end
    endcase
    a.store_empty = (n == 0);
    a.fill_level = 11'(n);
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // Monitor: tracks every accepted word, predicts answers and checks them
  always @(posedge clk) begin : monitor
    ans_word_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg.valid && cfg.ready) begin
        cap_reg = cfg.word;
        head_pos = 0;
        held = 0;
        quiet_cycles = 0;
      end
      if (req.valid && req.ready) begin
        quiet_cycles = 0;
        if (apply_request(req.word, want)) pending_answers.push_back(want);
      end
      if (ans.valid && ans.ready) begin
        quiet_cycles = 0;
        if (pending_answers.size() == 0) begin
          $display("%0t: answer word with none expected", $time);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          check_field("answer_kind", 32'(want.answer_kind), 32'(ans.word.answer_kind));
          check_field("range_first", 32'(want.range_first), 32'(ans.word.range_first));
          check_field("range_end", 32'(want.range_end), 32'(ans.word.range_end));
          check_field("near_x", want.near_x, ans.word.near_x);
          check_field("near_y", want.near_y, ans.word.near_y);
          check_field("store_empty", 32'(want.store_empty), 32'(ans.word.store_empty));
          check_field("fill_level", 32'(want.fill_level), 32'(ans.word.fill_level));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: ready follows a pattern of its own
  initial begin : answer_stalls
    int mode, len;
    ans.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 40);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        case (mode)
          0: ans.ready <= 1'b1;
          1: ans.ready <= 1'($urandom_range(0, 1));
          2: ans.ready <= (i >= len - 2);  // long stall
          default: ans.ready <= (i % 3) != 0;
        endcase
      end
    end
  end

  // Sends one request word, in bursts with random gaps between them
  task automatic send_word(input req_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.word <= w;
    do @(posedge clk); while (!req.ready);
    burst_left--;
  endtask

  // Unused fields carry random bits
  function automatic req_word_t make_req(req_kind_t kind, logic signed [31:0] a,
                                         logic signed [31:0] b);
    req_word_t w;
    w.req_type = kind;
    w.point_x = $urandom;
    w.point_y = $urandom;
    w.window_low = $urandom;
    w.window_high = $urandom;
    w.probe_x = $urandom;
    case (kind)
      REQ_WRITE: begin
        w.point_x = a;
        w.point_y = b;
      end
      REQ_WINDOW: begin
        w.window_low = a;
        w.window_high = b;
      end
      REQ_NEAREST: w.probe_x = a;
      default: ;
    endcase
    return w;
  endfunction

  task automatic put_point(input logic signed [31:0] x, input logic signed [31:0] y);
    send_word(make_req(REQ_WRITE, x, y));
  endtask

  task automatic ask_window(input logic signed [31:0] lo, input logic signed [31:0] hi);
    send_word(make_req(REQ_WINDOW, lo, hi));
  endtask

  task automatic ask_nearest(input logic signed [31:0] probe);
    send_word(make_req(REQ_NEAREST, probe, 0));
  endtask

  task automatic clear_store();
    send_word(make_req(REQ_CLEAR, 0, 0));
  endtask

  // Waits until every answer is in, then lets the block settle
  task automatic wait_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [10:0] value);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.word <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] clamp_x(longint v);
    if (v > X_MAX) return X_MAX;
    if (v < X_MIN) return X_MIN;
    return v[31:0];
  endfunction

  function automatic longint next_step();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 10) return 0;  // repeated x
    if (dice < 65) return longint'($urandom_range(1, 4 * ONE));
    if (dice < 95) return longint'($urandom_range(1, 1 << 22));
    return longint'($urandom_range(1, 1 << 28));
  endfunction

  // Random x around the span of the current series
  function automatic longint near_data();
    longint span;
    span = run_x - run_base + (longint'(1) << 21);
    return run_base - (longint'(1) << 20)
           + longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % span;
  endfunction

  // Mostly a rising series with queries over it, plus clears and noise words
  task automatic random_stream(input logic [10:0] capacity, input int count);
    longint lo, hi;
    int dice;
    req_word_t w;
    set_capacity(capacity);
    if ($urandom_range(0, 7) == 0) run_x = longint'(X_MIN);
    else run_x = longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29);
    run_base = run_x;
    last_step = 0;
    repeat (count) begin
      dice = $urandom_range(0, 99);
      if (dice < 45) begin
        last_step = next_step();
        run_x += last_step;
        if (run_x > X_MAX) begin
          // series wraps: x falls back, a broken sequence
          run_x = longint'(X_MIN) + longint'($urandom_range(0, 255));
          run_base = run_x;
        end
        put_point(clamp_x(run_x), $urandom);
      end else if (dice < 68) begin
        lo = near_data();
        case ($urandom_range(0, 9))
          0: hi = lo - longint'($urandom_range(1, 1 << 20));  // crossed window
          1, 2: hi = lo + (run_x - run_base);
          default: hi = lo + longint'($urandom_range(0, 1 << 22));
        endcase
        ask_window(clamp_x(lo), clamp_x(hi));
      end else if (dice < 85) begin
        if ($urandom_range(0, 3) == 0) ask_nearest(clamp_x(run_x - last_step / 2));
        else ask_nearest(clamp_x(near_data()));
      end else if (dice < 87) begin
        clear_store();
        run_base = run_x;
      end else begin
        w = make_req(req_kind_t'($urandom_range(0, 3)), $urandom, $urandom);
        send_word(w);
      end
    end
  endtask

  task automatic test_empty_store();
    ask_window(X_MIN, X_MAX);
    ask_window(0, 0);
    ask_nearest(X_MIN);
    ask_nearest(X_MAX);
  endtask

  // Window cases: all left, all right, crossed, duplicates, full span
  task automatic test_window_edges();
    put_point(100 * ONE, X_MAX);
    put_point(200 * ONE, X_MIN);
    put_point(200 * ONE, 7);
    put_point(300 * ONE, -7);
    ask_window(400 * ONE, 500 * ONE);
    ask_window(-10 * ONE, 50 * ONE);
    ask_window(250 * ONE, 150 * ONE);
    ask_window(200 * ONE, 200 * ONE);
    ask_window(X_MIN, X_MAX);
    ask_window(150 * ONE, 250 * ONE);
  endtask

  // Probes halfway between points and beyond both ends
  task automatic test_nearest_ties();
    ask_nearest(150 * ONE);
    ask_nearest(250 * ONE);
    ask_nearest(X_MIN);
    ask_nearest(X_MAX);
    ask_nearest(201 * ONE);
  endtask

  task automatic test_clear();
    clear_store();
    ask_nearest(0);
    put_point(X_MAX, X_MIN);
    ask_nearest(X_MIN);
    ask_window(X_MAX, X_MAX);
    ask_window(X_MIN, X_MIN);
  endtask

  // Several capacities, clamped values and both extremes among them
  task automatic test_random_phases();
    random_stream(11'd0, 40);
    random_stream(11'd1, 20);
    random_stream(11'd3, 40);
    random_stream(11'd17, 60);
    random_stream(11'd2047, 60);
    random_stream(11'($urandom_range(4, 40)), 50);
    random_stream(11'd1025, 30);
    random_stream(11'd2, 30);
  endtask

  // Large ring: overwrite past the last slot, query around the wrap
  task automatic test_full_wrap();
    set_capacity(11'd250);
    run_x = -(longint'(1) << 30);
    run_base = run_x;
    last_step = 0;
    for (int i = 0; i < 260; i++) begin
      last_step = longint'($urandom_range(0, 1 << 20));
      run_x += last_step;
      put_point(clamp_x(run_x), $urandom);
      if (i == 124 || i == 248 || i == 249 || i == 250 || i == 259) begin
        ask_window(clamp_x(near_data()), clamp_x(run_x));
        ask_nearest(clamp_x(run_x - last_step / 2));
        ask_nearest(clamp_x(near_data()));
      end
    end
    ask_window(X_MIN, X_MAX);
  endtask

  initial begin
    head_pos = 0;
    held = 0;
    cap_reg = 11'd1024;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_x[i] = '0;
      ring_y[i] = '0;
    end
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.word <= '0;
    cfg.valid <= 1'b0;
    cfg.word <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_window_edges();
    test_nearest_ties();
    test_clear();
    test_random_phases();
    test_full_wrap();

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: time_indexed_ring_search.f
rtl/tirs_pkg.sv
rtl/tirs_if.sv
rtl/tirs_point_ram.sv
rtl/time_indexed_ring_search.sv
sim/tb_top.sv
